[rtl/core/shx_pkg.sv]
`timescale 1ns / 1ps
package shx_pkg;
  localparam int NodeSlotsDefault   = 513;
  localparam int SymbolCountDefault = 256;
  localparam int NodeW  = 10;
  localparam int WeightW = 16;

  typedef enum logic [3:0] {
    ST_FIRST0, ST_LAST, ST_COUNTS, ST_FIRSTN,
    ST_CLEAR, ST_SCAN, ST_MERGE, ST_ZERO1, ST_ZERO2,
    ST_DECODE, ST_WALK, ST_EMIT, ST_FLUSH
  } state_t;
endpackage

[rtl/core/static_huffman_expander.sv]
`timescale 1ns / 1ps
// Channel | Dir | Handshake              | Payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata[7:0] stream_byte
// m_axis  | out | m_axis_tvalid/tready   | tdata[7:0] symbol, tuser stream_end, tlast last_of_run
// Header bytes are taken without stalling; the input is held off from the terminating zero on.
// The build reads one weight per cycle: each new node costs a scan of slots 0..nf-1, writes in
// MERGE, ZERO1, ZERO2 (nf is the next free slot, from SYMBOL_COUNT+1); a last scan ends it.
// A code byte is accepted in DECODE, then walked with a child read and a WALK step per bit;
// FLUSH sends a held result with its last flag, and output stalls can hold WALK and FLUSH.
// Reset (rst, synchronous) and every end of stream start a weight clear of all NODE_SLOTS slots.
module static_huffman_expander #(
  parameter int NODE_SLOTS   = shx_pkg::NodeSlotsDefault,
  parameter int SYMBOL_COUNT = shx_pkg::SymbolCountDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] stream_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol
  output logic       m_axis_tuser,   // [0] stream_end
  output logic       m_axis_tlast
);
  localparam int NW = shx_pkg::NodeW;
  localparam int WW = shx_pkg::WeightW;
  localparam logic [NW-1:0] SLOTS = NW'(NODE_SLOTS);
  localparam logic [NW-1:0] EOSN  = NW'(SYMBOL_COUNT);

  logic [WW-1:0] wmem [NODE_SLOTS];
  logic [NW-1:0] c0mem [NODE_SLOTS];
  logic [NW-1:0] c1mem [NODE_SLOTS];

  shx_pkg::state_t state;
  logic [7:0]    range_first, range_last, byte_q;
  logic [8:0]    count_index;
  logic [NW-1:0] root_index, walk_node, nf, scan_i, m1, m2, mem_idx;
  logic [WW-1:0] w1, w2, wrd;
  logic          h1, h2, rd_valid, merge_ph;
  logic [2:0]    bit_i;
  logic          out_v, out_eos, out_last;
  logic [7:0]    out_sym;
  logic [NW-1:0] crd0, crd1;
  logic          hold_v, hold_eos;
  logic [7:0]    hold_sym;

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == shx_pkg::ST_FIRST0 || state == shx_pkg::ST_LAST ||
    state == shx_pkg::ST_COUNTS || state == shx_pkg::ST_FIRSTN ||
    state == shx_pkg::ST_DECODE);
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_sym;
  assign m_axis_tuser  = out_eos;
  assign m_axis_tlast  = out_last;

  // Single read port per memory, registered.
  always_ff @(posedge clk) begin
    wrd  <= wmem[mem_idx];
    crd0 <= c0mem[mem_idx];
    crd1 <= c1mem[mem_idx];
  end

  logic cur_bit;
  logic [NW-1:0] child;
  logic out_free, out_load;
  assign cur_bit = byte_q[bit_i];
  assign child = cur_bit ? crd1 : crd0;
  assign out_free = !out_v || m_axis_tready;
  assign out_load = out_free && (state == shx_pkg::ST_FLUSH ||
    (state == shx_pkg::ST_WALK && child <= EOSN && hold_v));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shx_pkg::ST_CLEAR;
      out_v <= 1'b0;
      hold_v <= 1'b0;
      root_index <= '0; walk_node <= '0;
      range_first <= '0; range_last <= '0; count_index <= '0;
      mem_idx <= '0; scan_i <= '0; rd_valid <= 1'b0;
      h1 <= 1'b0; h2 <= 1'b0; merge_ph <= 1'b0;
    end else begin
      if (out_load) out_v <= 1'b1;
      else if (out_v && m_axis_tready) out_v <= 1'b0;
      unique case (state)
        shx_pkg::ST_FIRST0: if (s_fire) begin
          range_first <= s_axis_tdata; state <= shx_pkg::ST_LAST;
        end
        shx_pkg::ST_LAST: if (s_fire) begin
          range_last <= s_axis_tdata;
          if (range_first <= s_axis_tdata) begin
            count_index <= {1'b0, range_first}; state <= shx_pkg::ST_COUNTS;
          end else state <= shx_pkg::ST_FIRSTN;
        end
        shx_pkg::ST_COUNTS: if (s_fire) begin
          if (count_index < 9'(SYMBOL_COUNT) && {1'b0, count_index} < SLOTS)
            wmem[NW'(count_index)] <= WW'(s_axis_tdata);
          if (count_index >= {1'b0, range_last}) state <= shx_pkg::ST_FIRSTN;
          else count_index <= count_index + 9'd1;
        end
        shx_pkg::ST_FIRSTN: if (s_fire) begin
          if (s_axis_tdata != 8'd0) begin
            range_first <= s_axis_tdata; state <= shx_pkg::ST_LAST;
          end else begin
            if (EOSN < SLOTS) wmem[EOSN] <= WW'(1);
            nf <= EOSN + NW'(1);
            scan_i <= '0; mem_idx <= '0; rd_valid <= 1'b0;
            h1 <= 1'b0; h2 <= 1'b0;
            state <= shx_pkg::ST_SCAN;
          end
        end
        shx_pkg::ST_SCAN: begin
          if (nf >= SLOTS) begin
            state <= shx_pkg::ST_MERGE; merge_ph <= 1'b1;
          end else begin
            if (rd_valid && wrd != '0) begin
              if (!h1 || wrd < w1) begin
                m2 <= m1; w2 <= w1; h2 <= h1;
                m1 <= scan_i - NW'(1); w1 <= wrd; h1 <= 1'b1;
              end else if (!h2 || wrd < w2) begin
                m2 <= scan_i - NW'(1); w2 <= wrd; h2 <= 1'b1;
              end
            end
            if (scan_i == nf) begin
              rd_valid <= 1'b0;
              state <= shx_pkg::ST_MERGE; merge_ph <= 1'b0;
            end else begin
              mem_idx <= scan_i + NW'(1);
              scan_i <= scan_i + NW'(1);
              rd_valid <= 1'b1;
            end
          end
        end
        shx_pkg::ST_MERGE: begin
          if (merge_ph || !h2) begin
            root_index <= nf - NW'(1); walk_node <= nf - NW'(1);
            mem_idx <= nf - NW'(1);
            if (nf - NW'(1) <= EOSN) begin
              hold_v <= 1'b1; hold_sym <= '0; hold_eos <= 1'b1;
              state <= shx_pkg::ST_FLUSH;
            end else state <= shx_pkg::ST_DECODE;
          end else begin
            wmem[nf] <= w1 + w2;
            c0mem[nf] <= m1; c1mem[nf] <= m2;
            state <= shx_pkg::ST_ZERO1;
          end
        end
        shx_pkg::ST_ZERO1: begin
          wmem[m1] <= '0;
          state <= shx_pkg::ST_ZERO2;
        end
        shx_pkg::ST_ZERO2: begin
          wmem[m2] <= '0;
          nf <= nf + NW'(1);
          scan_i <= '0; mem_idx <= '0; rd_valid <= 1'b0;
          h1 <= 1'b0; h2 <= 1'b0;
          state <= shx_pkg::ST_SCAN;
        end
        shx_pkg::ST_CLEAR: begin
          if (scan_i < SLOTS) wmem[scan_i] <= '0;
          if (scan_i >= SLOTS - NW'(1)) state <= shx_pkg::ST_FIRST0;
          else scan_i <= scan_i + NW'(1);
        end
        shx_pkg::ST_DECODE: if (s_fire) begin
          byte_q <= s_axis_tdata; bit_i <= 3'd7;
          mem_idx <= walk_node; state <= shx_pkg::ST_WALK;
        end
        shx_pkg::ST_WALK: begin
          if (child > EOSN) begin
            walk_node <= child; mem_idx <= child;
            if (bit_i == 3'd0) state <= hold_v ? shx_pkg::ST_FLUSH : shx_pkg::ST_DECODE;
            else begin bit_i <= bit_i - 3'd1; state <= shx_pkg::ST_EMIT; end
          end else if (!hold_v || out_free) begin
            // A decoded result waits here until it is known whether it ends the byte.
            if (hold_v) begin
              out_sym <= hold_sym; out_eos <= hold_eos; out_last <= 1'b0;
            end
            hold_v <= 1'b1;
            hold_sym <= (child == EOSN) ? 8'd0 : child[7:0];
            hold_eos <= (child == EOSN);
            walk_node <= root_index; mem_idx <= root_index;
            if (child == EOSN || bit_i == 3'd0) state <= shx_pkg::ST_FLUSH;
            else begin bit_i <= bit_i - 3'd1; state <= shx_pkg::ST_EMIT; end
          end
        end
        shx_pkg::ST_EMIT: state <= shx_pkg::ST_WALK;
        shx_pkg::ST_FLUSH: if (out_free) begin
          out_sym <= hold_sym; out_eos <= hold_eos; out_last <= 1'b1;
          hold_v <= 1'b0;
          if (hold_eos) begin
            scan_i <= '0; state <= shx_pkg::ST_CLEAR;
          end else state <= shx_pkg::ST_DECODE;
        end
        default: state <= shx_pkg::ST_FIRST0;
      endcase
    end
  end

  ap_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !hold_v) else $error("input offered while a result is held");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    out_v && !m_axis_tready |=> out_v) else $error("result dropped");
  ap_stable: assert property (@(posedge clk) disable iff (rst)
    out_v && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
    $stable(m_axis_tlast)) else $error("result changed while waiting");
  ap_eos_last: assert property (@(posedge clk) disable iff (rst)
    out_v && out_eos |-> out_last) else $error("end without last");
endmodule

[bench/static_huffman_expander_test.sv]
`timescale 1ns / 1ps
module static_huffman_expander_test;
  localparam int Slots = shx_pkg::NodeSlotsDefault;
  localparam int Syms = shx_pkg::SymbolCountDefault;
  localparam int CycleLimit = 3000000;
  localparam int HoldCycles = 400;

  typedef enum int {HDR_FIRST0, HDR_LAST, HDR_COUNTS, HDR_FIRSTN, CODE_DECODE} hdr_phase_t;

  typedef struct {
    logic [7:0] sym;
    logic       eos;
    logic       last;
  } symbol_item_t;

  class huff_scoreboard;
    bit [15:0] weight[Slots];
    bit [9:0] kid0[Slots];
    bit [9:0] kid1[Slots];
    bit [9:0] up[Slots];
    bit has_up[Slots];
    int root, walk, rfirst, rlast, cidx;
    hdr_phase_t phase;
    symbol_item_t expected_symbols[$];
    int mismatches, checked, eos_seen;

    function new();
      foreach (weight[i]) begin
        weight[i] = 0; kid0[i] = 0; kid1[i] = 0; has_up[i] = 0;
      end
      root = 0; walk = 0; rfirst = 0; rlast = 0; cidx = 0;
      phase = HDR_FIRST0;
      mismatches = 0; checked = 0; eos_seen = 0;
    endfunction

    function int wt(int i);
      return (i < Slots) ? weight[i] : 0;
    endfunction

    function void put_wt(int i, int v);
      if (i < Slots) weight[i] = v[15:0];
    endfunction

    function void make_tree();
      int nf, m1, m2, w;
      bit h1, h2;
      nf = Syms + 1;
      foreach (has_up[i]) has_up[i] = 0;
      put_wt(Syms, 1);
      forever begin
        if (nf >= Slots) break;
        m1 = 0; m2 = 0; h1 = 0; h2 = 0;
        for (int i = 0; i < nf; i++) begin
          w = wt(i);
          if (w == 0) continue;
          if (!h1 || w < wt(m1)) begin
            m2 = m1; h2 = h1; m1 = i; h1 = 1;
          end else if (!h2 || w < wt(m2)) begin
            m2 = i; h2 = 1;
          end
        end
        if (!h2) break;
        put_wt(nf, wt(m1) + wt(m2));
        put_wt(m1, 0);
        put_wt(m2, 0);
        kid0[nf] = m1[9:0];
        kid1[nf] = m2[9:0];
        up[m1] = nf[9:0]; has_up[m1] = 1;
        up[m2] = nf[9:0]; has_up[m2] = 1;
        nf++;
      end
      root = (nf - 1) & 10'h3ff;
      walk = root;
    endfunction

    function void restart_header();
      foreach (weight[i]) weight[i] = 0;
      phase = HDR_FIRST0;
    endfunction

    function void note_byte(logic [7:0] b);
      symbol_item_t produced[$];
      symbol_item_t r;
      int node;
      case (phase)
        HDR_FIRST0: begin
          rfirst = b; phase = HDR_LAST;
        end
        HDR_LAST: begin
          rlast = b;
          if (rfirst <= rlast) begin
            cidx = rfirst; phase = HDR_COUNTS;
          end else begin
            phase = HDR_FIRSTN;
          end
        end
        HDR_COUNTS: begin
          if (cidx < Syms) put_wt(cidx, b);
          if (cidx >= rlast) phase = HDR_FIRSTN;
          else cidx = (cidx + 1) & 9'h1ff;
        end
        HDR_FIRSTN: begin
          if (b != 0) begin
            rfirst = b; phase = HDR_LAST;
          end else begin
            make_tree();
            if (root <= Syms) begin
              r.sym = 0; r.eos = 1; r.last = 0;
              produced.push_back(r);
              restart_header();
            end else begin
              phase = CODE_DECODE;
            end
          end
        end
        default: begin
          for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            node = walk;
            if (node < Slots) node = b[bit_i] ? kid1[node] : kid0[node];
            else node = 0;
            if (node > Syms) begin
              walk = node;
              continue;
            end
            if (node == Syms) begin
              r.sym = 0; r.eos = 1; r.last = 0;
              produced.push_back(r);
              restart_header();
              break;
            end
            r.sym = node[7:0]; r.eos = 0; r.last = 0;
            produced.push_back(r);
            walk = root;
          end
        end
      endcase
      if (produced.size() > 0) produced[produced.size() - 1].last = 1;
      foreach (produced[i]) expected_symbols.push_back(produced[i]);
    endfunction

    function void check_symbol(logic [7:0] sym, logic eos, logic last);
      symbol_item_t e;
      checked++;
      if (expected_symbols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected item: symbol %0d eos %0b last %0b", sym, eos, last);
        return;
      end
      e = expected_symbols.pop_front();
      if (eos) eos_seen++;
      if (sym !== e.sym || eos !== e.eos || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected symbol %0d eos %0b last %0b, got %0d %0b %0b",
                   e.sym, e.eos, e.last, sym, eos, last);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;

  huff_scoreboard sb;
  int send_idle_pct, recv_stall_pct, bytes_sent, frames_sent;
  int cycle_count = 0;
  logic hold_active;
  bit hold_next;
  event long_hold_ev;

  static_huffman_expander u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    hold_active = 0;
    forever begin
      @(long_hold_ev);
      hold_active = 1;
      repeat (HoldCycles) @(negedge clk);
      hold_active = 0;
    end
  end

  always @(negedge clk) begin
    if (hold_active) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_symbol(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk) s_axis_tvalid <= 0;
    while (sb.expected_symbols.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_code(int leaf, ref bit bit_queue[$]);
    bit path[$];
    int n;
    n = leaf;
    while (n != sb.root) begin
      path.push_front(sb.kid1[sb.up[n]] == n[9:0]);
      n = sb.up[n];
    end
    foreach (path[i]) bit_queue.push_back(path[i]);
  endtask

  // Sends a header; if a tree results, maybe a noise byte, then random codes ending in EOS.
  task automatic send_frame(logic [7:0] hdr[$], int nsyms, bit noise);
    bit bit_queue[$];
    int leaves[$];
    int cur;
    bit ended;
    logic [7:0] b;
    foreach (hdr[i]) send_byte(hdr[i]);
    if (sb.phase != CODE_DECODE) return;
    if (hold_next) begin
      hold_next = 0;
      -> long_hold_ev;
    end
    if (noise) begin
      send_byte(8'($urandom_range(255)));
      if (sb.phase != CODE_DECODE) return;
    end
    for (int i = 0; i < Syms; i++) if (sb.has_up[i]) leaves.push_back(i);
    cur = sb.walk;
    ended = 0;
    while (cur > Syms) begin
      if (cur == sb.root) break;
      bit_queue.push_back(0);
      cur = sb.kid0[cur];
      if (cur == Syms) ended = 1;
    end
    if (!ended) begin
      for (int k = 0; k < nsyms; k++)
        add_code(leaves[$urandom_range(leaves.size() - 1)], bit_queue);
      add_code(Syms, bit_queue);
    end
    while (bit_queue.size() % 8 != 0) bit_queue.push_back(1'($urandom_range(1)));
    for (int i = 0; i < bit_queue.size(); i += 8) begin
      for (int j = 0; j < 8; j++) b[7 - j] = bit_queue[i + j];
      send_byte(b);
    end
    frames_sent++;
  endtask

  task automatic random_frame(int nsyms, bit noise);
    logic [7:0] hdr[$];
    int nruns, f, l;
    nruns = $urandom_range(1, 3);
    for (int r = 0; r < nruns; r++) begin
      f = (r == 0 && $urandom_range(3) == 0) ? 0 : $urandom_range(1, 255);
      if ($urandom_range(9) == 0) l = (f > 0) ? $urandom_range(f - 1) : 0;
      else l = (f + $urandom_range(4) > 255) ? 255 : f + $urandom_range(4);
      hdr.push_back(8'(f));
      hdr.push_back(8'(l));
      if (f <= l)
        for (int i = f; i <= l; i++)
          hdr.push_back(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255)));
    end
    hdr.push_back(0);
    send_frame(hdr, nsyms, noise);
  endtask

  initial begin
    sb = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    hold_next = 0;
    bytes_sent = 0;
    frames_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 0;

    // A zero first byte opens a run; an empty run follows; extreme counts.
    send_frame('{8'd0, 8'd1, 8'd255, 8'd1, 8'd10, 8'd3, 8'd0}, 4, 0);
    // A tree holding only end-of-stream ends at once.
    send_frame('{8'd5, 8'd5, 8'd0, 8'd0}, 0, 0);
    // Top of the symbol range with equal weights to exercise tie order.
    send_frame('{8'd252, 8'd255, 8'd7, 8'd7, 8'd7, 8'd128, 8'd0}, 6, 0);
    wait_drained();

    for (int phase_i = 0; phase_i < 4; phase_i++) begin
      send_idle_pct = (phase_i == 1) ? 63 : (phase_i == 3) ? 34 : 0;
      recv_stall_pct = (phase_i == 2) ? 63 : (phase_i == 3) ? 34 : 0;
      for (int k = 0; k < 1; k++) begin
        if (phase_i == 0 && k == 0) hold_next = 1;
        random_frame($urandom_range(12, 24) * ((phase_i == 0 && k == 0) ? 2 : 1),
                     $urandom_range(9) == 0);
      end
      wait_drained();
    end

    @(negedge clk) s_axis_tvalid <= 0;
    wait_drained();
    $display("Sent %0d bytes in %0d coded frames; checked %0d symbols, %0d end markers.",
             bytes_sent, frames_sent, sb.checked, sb.eos_seen);
    if (sb.mismatches == 0 && sb.expected_symbols.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("Mismatches: %0d, outstanding: %0d", sb.mismatches, sb.expected_symbols.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[static_huffman_expander.f]
rtl/core/shx_pkg.sv
rtl/core/static_huffman_expander.sv
bench/static_huffman_expander_test.sv
